// ===== design/tse_pkg.sv =====
// Shared types and constants for the text sanitiser and escaper.
`default_nettype none
package tse_pkg;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] MAX_LENGTH_RST    = 8'd120;
    localparam logic       ESCAPE_ENABLE_RST = 1'b1;

    localparam int CMD_DEPTH_DEF = 4;

    localparam int ADDR_W = 3;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_MAX_LENGTH    = 1'b0,
        REG_ESCAPE_ENABLE = 1'b1
    } reg_idx_t;

    // One classified request: which results it expands to, in order.
    typedef struct packed {
        logic       gap;
        logic       esc;
        logic       chr;
        logic       endm;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       end_mark;
    } result_t;

endpackage
`default_nettype wire

// ===== design/tse_front.sv =====
// Front end: classifies each byte and tracks the per-field state.
`default_nettype none
module tse_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          end_of_field,
    input  wire logic [7:0]    max_length,
    input  wire logic          escape_enable,
    output tse_pkg::cmd_t      cmd,
    output logic               cmd_valid
);
    import tse_pkg::*;

    logic       pending_gap_reg, pending_gap_next;
    logic [7:0] kept_count_reg, kept_count_next;
    logic       stopped_reg, stopped_next;

    logic       is_ws;
    logic       is_ctrl;
    logic [7:0] cnt;
    logic       stop;
    logic       emit_gap;
    logic       emit_chr;

    assign is_ws   = ((in_byte >= CH_TAB) && (in_byte <= CH_CR)) || (in_byte == CH_SPACE);
    assign is_ctrl = (in_byte < CH_SPACE) || (in_byte == CH_DEL);

    always_comb
    begin
        pending_gap_next = pending_gap_reg;
        kept_count_next  = kept_count_reg;
        stopped_next     = stopped_reg;
        cnt              = kept_count_reg;
        stop             = 1'b0;
        emit_gap         = 1'b0;
        emit_chr         = 1'b0;
        if (!stopped_reg)
        begin
            if (is_ws)
            begin
                pending_gap_next = (kept_count_reg != 8'd0);
            end
            else if (!is_ctrl)
            begin
                if (pending_gap_reg && (cnt < max_length))
                begin
                    // A gap that would be the last kept byte ends the field.
                    if (({1'b0, cnt} + 9'd1) >= {1'b0, max_length})
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        emit_gap = 1'b1;
                        cnt      = cnt + 8'd1;
                    end
                end
                if (!stop)
                begin
                    if (cnt >= max_length)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        emit_chr = 1'b1;
                        cnt      = cnt + 8'd1;
                    end
                end
                pending_gap_next = 1'b0;
                kept_count_next  = cnt;
                stopped_next     = stop;
            end
        end
        if (end_of_field)
        begin
            pending_gap_next = 1'b0;
            kept_count_next  = 8'd0;
            stopped_next     = 1'b0;
        end
    end

    always_comb
    begin
        cmd.gap   = emit_gap;
        cmd.chr   = emit_chr;
        cmd.esc   = emit_chr && escape_enable &&
                    ((in_byte == CH_BSLASH) || (in_byte == CH_QUOTE));
        cmd.endm  = end_of_field;
        cmd.ch    = in_byte;
        cmd_valid = accept && (emit_gap || emit_chr || end_of_field);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_gap_reg <= 1'b0;
            kept_count_reg  <= 8'd0;
            stopped_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pending_gap_reg <= pending_gap_next;
            kept_count_reg  <= kept_count_next;
            stopped_reg     <= stopped_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/tse_cmd_fifo.sv =====
// Short request queue between the front end and the back end.
`default_nettype none
module tse_cmd_fifo #(
    parameter int DEPTH = tse_pkg::CMD_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  tse_pkg::cmd_t      wr_data,
    input  wire logic          rd_en,
    output tse_pkg::cmd_t      rd_data,
    output logic               full,
    output logic               empty
);
    import tse_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          entries_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/tse_back.sv =====
// Back end: expands each request into its result bytes, one per cycle while the output register is free.
`default_nettype none
module tse_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  tse_pkg::cmd_t      cmd,
    input  wire logic          cmd_empty,
    output logic               cmd_take,
    output tse_pkg::result_t   result,
    output logic               empty,
    input  wire logic          pop
);
    import tse_pkg::*;

    cmd_t    work_reg, work_next;
    logic    work_valid_reg, work_valid_next;
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;

    logic    out_free;
    logic    emitting;
    cmd_t    left;
    result_t item;
    logic    last_item;

    assign out_free = !out_valid_reg || pop;
    assign emitting = work_valid_reg && out_free;

    // Results leave in the order gap space, escape, byte, end marker.
    always_comb
    begin
        left = work_reg;
        item = '{out_byte: 8'd0, is_data: 1'b0, end_mark: 1'b1};
        if (work_reg.gap)
        begin
            item     = '{out_byte: CH_SPACE, is_data: 1'b1, end_mark: 1'b0};
            left.gap = 1'b0;
        end
        else if (work_reg.esc)
        begin
            item     = '{out_byte: CH_BSLASH, is_data: 1'b1, end_mark: 1'b0};
            left.esc = 1'b0;
        end
        else if (work_reg.chr)
        begin
            item     = '{out_byte: work_reg.ch, is_data: 1'b1, end_mark: 1'b0};
            left.chr = 1'b0;
        end
        else
        begin
            left.endm = 1'b0;
        end
        last_item = !(left.gap || left.esc || left.chr || left.endm);
    end

    always_comb
    begin
        cmd_take        = !cmd_empty && (!work_valid_reg || (emitting && last_item));
        work_next       = work_reg;
        work_valid_next = work_valid_reg;
        if (cmd_take)
        begin
            work_next       = cmd;
            work_valid_next = 1'b1;
        end
        else if (emitting)
        begin
            work_next       = left;
            work_valid_next = !last_item;
        end
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_next       = item;
            out_valid_next = emitting;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire

// ===== design/text_sanitize_escape_core.sv =====
// Top level of the text sanitiser: configuration registers and the two halves.
//
// Input bytes are pushed with push while full is low, one field at a time;
// end_of_field marks the final byte. Each byte yields up to four results
// (gap space, escaping backslash, the byte, end marker), read while empty is
// low and taken with pop. A byte is taken every cycle while the request
// queue has room; results leave at one per cycle while pop is high, so the
// sustained input rate is one byte per cycle divided by the number of results
// each byte produces. A byte's request enters the queue at the accepting edge,
// then passes the expansion register and the output register before its
// first result appears. When pop stays low the output register holds,
// expansion stops, and once the request queue of CMD_DEPTH entries fills, full
// rises. Dropped bytes take no queue entry. The registers max_length (address
// 0) and escape_enable (address 4) sit on the APB port; the user writes them
// only while the block is idle, not enforced by the block. Reset sets them
// to 120 and 1, empties the queue and output, and clears the field state.
`default_nettype none
module text_sanitize_escape_core #(
    parameter int CMD_DEPTH = tse_pkg::CMD_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tse_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic [7:0]                  in_byte,
    input  wire logic                        end_of_field,
    input  wire logic                        push,
    output logic                             full,
    output logic      [7:0]                  out_byte,
    output logic                             is_data,
    output logic                             end_mark,
    output logic                             empty,
    input  wire logic                        pop
);
    import tse_pkg::*;

    logic [7:0] max_length_reg;
    logic       escape_enable_reg;
    reg_idx_t   reg_idx;
    logic       cfg_write;

    logic       accept;
    cmd_t       front_cmd;
    logic       front_valid;
    cmd_t       head_cmd;
    logic       q_full;
    logic       q_empty;
    logic       q_take;
    result_t    result;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            REG_MAX_LENGTH:    prdata = {24'd0, max_length_reg};
            REG_ESCAPE_ENABLE: prdata = {31'd0, escape_enable_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg    <= MAX_LENGTH_RST;
            escape_enable_reg <= ESCAPE_ENABLE_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_MAX_LENGTH:    max_length_reg    <= pwdata[7:0];
                REG_ESCAPE_ENABLE: escape_enable_reg <= pwdata[0];
                default:           max_length_reg    <= max_length_reg;
            endcase
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    tse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_field  (end_of_field),
        .max_length    (max_length_reg),
        .escape_enable (escape_enable_reg),
        .cmd           (front_cmd),
        .cmd_valid     (front_valid)
    );

    tse_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_cmd),
        .rd_en   (q_take),
        .rd_data (head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    tse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (q_empty),
        .cmd_take  (q_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    assign out_byte = result.out_byte;
    assign is_data  = result.is_data;
    assign end_mark = result.end_mark;

endmodule
`default_nettype wire
